/* sv/bmg_pkg.sv */
// shared constants, types and the cordic arctangent table for the gaussian pipeline
// depends on nothing; the module files refer to it by scoped names
package bmg_pkg;

    localparam int LOG_FRAC_BITS = 24;
    localparam int LZ_W          = 5;
    localparam int LG_W          = 30;
    localparam int R2_W          = 30;
    localparam int SQRT_BITS     = 23;
    localparam int REM_W         = 48;
    localparam int CORDIC_STEPS  = 16;
    localparam int Z_W           = 31;
    localparam int ZS_W          = 34;
    localparam int XY_W          = 26;
    localparam int OUT_W         = 20;

    localparam logic [31:0] LN2_Q32     = 32'd2977044472;
    localparam logic [30:0] HALF_PI_Q30 = 31'h6487ED51;
    localparam logic [31:0] GAIN_Q32    = 32'd2608131496;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 20'sh7FFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 20'sh80000;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quad;

    typedef struct packed {
        t_quad          quad;
        logic [Z_W-1:0] z;
    } t_angle;

    // arctangent of 2^-idx, q2.30
    function automatic logic [31:0] atan_q30(input logic [3:0] idx);
        logic [31:0] v;
        case (idx)
            4'd0:    v = 32'h3243F6A8;
            4'd1:    v = 32'h1DAC6705;
            4'd2:    v = 32'h0FADBAFC;
            4'd3:    v = 32'h07F56EA6;
            4'd4:    v = 32'h03FEAB76;
            4'd5:    v = 32'h01FFD55B;
            4'd6:    v = 32'h00FFFAAA;
            4'd7:    v = 32'h007FFF55;
            4'd8:    v = 32'h003FFFEA;
            4'd9:    v = 32'h001FFFFD;
            4'd10:   v = 32'h000FFFFF;
            4'd11:   v = 32'h0007FFFF;
            4'd12:   v = 32'h0003FFFF;
            4'd13:   v = 32'h0001FFFF;
            4'd14:   v = 32'h0000FFFF;
            default: v = 32'h00007FFF;
        endcase
        return v;
    endfunction

endpackage

/* sv/bmg_if.sv */
// valid/ready channel interfaces for the uniform input pair and the normal output pair
// depends on nothing
interface bmg_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] u_radius;
    logic [31:0] u_angle;
    modport source(output valid, output u_radius, output u_angle, input ready);
    modport sink(input valid, input u_radius, input u_angle, output ready);
endinterface

interface bmg_out_if;
    logic               valid;
    logic               ready;
    logic signed [19:0] normal_cos;
    logic signed [19:0] normal_sin;
    modport source(output valid, output normal_cos, output normal_sin, input ready);
    modport sink(input valid, input normal_cos, input normal_sin, output ready);
endinterface

/* sv/box_muller_gaussian.sv */
// Box-Muller gaussian generator: each item of two uniform q0.32 samples gives a pair
// of q4.16 normal samples. Fully pipelined, one item per clock while the output is
// taken. The pipeline is made of the 24 squaring stages of the log, the 23 bit
// stages of the square root and the 16 cordic stages, plus the multiply and
// register stages around them. When the result
// at the output is not taken, the whole pipeline holds and the input is not ready.
// depends on bmg_pkg, bmg_if, bmg_log, bmg_sqrt, bmg_cordic
module box_muller_gaussian (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bmg_in_if.sink        i_in,
    bmg_out_if.source     o_out
);

    logic                              w_en;
    logic                              w_log_valid;
    logic [bmg_pkg::R2_W-1:0]          w_r2;
    bmg_pkg::t_angle                   w_log_angle;
    logic                              w_sqrt_valid;
    logic [bmg_pkg::SQRT_BITS-1:0]     w_rad;
    bmg_pkg::t_angle                   w_sqrt_angle;
    logic                              w_out_valid;

    // pipeline advances unless a result is waiting
    assign w_en       = !w_out_valid || o_out.ready;
    assign i_in.ready = w_en;
    assign o_out.valid = w_out_valid;

    bmg_log u_log (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (i_in.valid),
        .i_u_radius (i_in.u_radius),
        .i_u_angle  (i_in.u_angle),
        .o_valid    (w_log_valid),
        .o_r2       (w_r2),
        .o_angle    (w_log_angle)
    );

    bmg_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_log_valid),
        .i_r2    (w_r2),
        .i_angle (w_log_angle),
        .o_valid (w_sqrt_valid),
        .o_rad   (w_rad),
        .o_angle (w_sqrt_angle)
    );

    bmg_cordic u_cordic (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_valid      (w_sqrt_valid),
        .i_rad        (w_rad),
        .i_angle      (w_sqrt_angle),
        .o_valid      (w_out_valid),
        .o_normal_cos (o_out.normal_cos),
        .o_normal_sin (o_out.normal_sin)
    );

    // pipeline empties on reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");

    // radius stays below the q4.16 limits, so no clamp ever fires
    a_no_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.normal_cos != bmg_pkg::OUT_MAX)
                     && (o_out.normal_cos != bmg_pkg::OUT_MIN)
                     && (o_out.normal_sin != bmg_pkg::OUT_MAX)
                     && (o_out.normal_sin != bmg_pkg::OUT_MIN))
        else $error("output sample saturated");

    // input only backs off when a result is blocked
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> o_out.valid && !o_out.ready)
        else $error("input stalled without output backpressure");

endmodule

/* sv/bmg_log.sv */
// front end: angle scaling, normalization, -log2 by repeated squaring, times 2*ln2
// depends on bmg_pkg
module bmg_log (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [31:0]                 i_u_radius,
    input  logic [31:0]                 i_u_angle,
    output logic                        o_valid,
    output logic [bmg_pkg::R2_W-1:0]    o_r2,
    output bmg_pkg::t_angle             o_angle
);

    localparam int N = bmg_pkg::LOG_FRAC_BITS;

    logic [31:0]              w_u;
    logic [bmg_pkg::LZ_W-1:0] w_lz;
    logic [60:0]              w_zprod;

    logic                     r_a_valid;
    logic [31:0]              r_a_u;
    logic [bmg_pkg::LZ_W-1:0] r_a_lz;
    bmg_pkg::t_angle          r_a_angle;

    logic                     r_valid [0:N];
    logic [31:0]              r_m     [0:N];
    logic [N-1:0]             r_frac  [0:N];
    logic [bmg_pkg::LZ_W-1:0] r_lz    [0:N];
    bmg_pkg::t_angle          r_angle [0:N];

    logic                     r_c_valid;
    logic [bmg_pkg::LG_W-1:0] r_c_lg;
    bmg_pkg::t_angle          r_c_angle;

    logic                     r_d_valid;
    logic [bmg_pkg::R2_W-1:0] r_d_r2;
    bmg_pkg::t_angle          r_d_angle;

    logic [61:0]              w_r2prod;

    // zero sample treated as the smallest one, leading zero count
    always_comb begin
        w_u  = (i_u_radius == 32'd0) ? 32'd1 : i_u_radius;
        w_lz = '0;
        for (int b = 0; b < 32; b++) begin
            if (w_u[b]) begin
                w_lz = bmg_pkg::LZ_W'(31 - b);
            end
        end
        w_zprod = 61'(i_u_angle[29:0]) * 61'(bmg_pkg::HALF_PI_Q30);
    end

    // stage a: count and angle product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_u           <= w_u;
            r_a_lz          <= w_lz;
            r_a_angle.quad  <= bmg_pkg::t_quad'(i_u_angle[31:30]);
            r_a_angle.z     <= w_zprod[60:30];
        end
    end

    // stage b: normalize mantissa to q1.31
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0]     <= r_a_u << r_a_lz;
            r_frac[0]  <= '0;
            r_lz[0]    <= r_a_lz;
            r_angle[0] <= r_a_angle;
        end
    end

    // one squaring per stage, one fraction bit each
    for (genvar g = 0; g < N; g++) begin : g_sq
        logic [63:0] w_sq;
        logic [32:0] w_t;

        assign w_sq = 64'(r_m[g]) * 64'(r_m[g]);
        assign w_t  = w_sq[63:31];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[g+1] <= r_valid[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[g+1]     <= w_t[32] ? w_t[32:1] : w_t[31:0];
                r_frac[g+1]  <= {r_frac[g][N-2:0], w_t[32]};
                r_lz[g+1]    <= r_lz[g];
                r_angle[g+1] <= r_angle[g];
            end
        end
    end

    // stage c: -log2 in q6.24
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (i_en) begin
            r_c_valid <= r_valid[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_lg    <= {6'(r_lz[N]) + 6'd1, 24'd0} - bmg_pkg::LG_W'(r_frac[N]);
            r_c_angle <= r_angle[N];
        end
    end

    // stage d: scale by 2*ln2
    assign w_r2prod = 62'(r_c_lg) * 62'(bmg_pkg::LN2_Q32);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (i_en) begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_r2    <= w_r2prod[60:31];
            r_d_angle <= r_c_angle;
        end
    end

    assign o_valid = r_d_valid;
    assign o_r2    = r_d_r2;
    assign o_angle = r_d_angle;

endmodule

/* sv/bmg_sqrt.sv */
// pipelined restoring square root, one root bit per stage
// depends on bmg_pkg
module bmg_sqrt (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic [bmg_pkg::R2_W-1:0]         i_r2,
    input  bmg_pkg::t_angle                  i_angle,
    output logic                             o_valid,
    output logic [bmg_pkg::SQRT_BITS-1:0]    o_rad,
    output bmg_pkg::t_angle                  o_angle
);

    localparam int N = bmg_pkg::SQRT_BITS;
    localparam int W = bmg_pkg::REM_W;

    logic            r_valid [0:N];
    logic [W-1:0]    r_rem   [0:N];
    logic [N-1:0]    r_q     [0:N];
    bmg_pkg::t_angle r_angle [0:N];

    // operand register, value shifted to q.40
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]   <= W'({i_r2, 16'd0});
            r_q[0]     <= '0;
            r_angle[0] <= i_angle;
        end
    end

    // try each root bit from the top down
    for (genvar k = 0; k < N; k++) begin : g_bit
        localparam int B = N - 1 - k;
        logic [W-1:0] w_delta;

        assign w_delta = (W'(r_q[k]) << (B + 1)) + (W'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[k+1] <= r_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_rem[k] >= w_delta) begin
                    r_rem[k+1] <= r_rem[k] - w_delta;
                    r_q[k+1]   <= r_q[k] | (N'(1) << B);
                end else begin
                    r_rem[k+1] <= r_rem[k];
                    r_q[k+1]   <= r_q[k];
                end
                r_angle[k+1] <= r_angle[k];
            end
        end
    end

    assign o_valid = r_valid[N];
    assign o_rad   = r_q[N];
    assign o_angle = r_angle[N];

    // the root is the floor: remainder never reaches 2q+1
    a_floor_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[N] |-> r_rem[N] <= W'({r_q[N], 1'b0}))
        else $error("square root remainder too large");

endmodule

/* sv/bmg_cordic.sv */
// gain prescale, sixteen cordic rotation stages, quadrant fold and q4.16 rounding
// depends on bmg_pkg
module bmg_cordic (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [bmg_pkg::SQRT_BITS-1:0]       i_rad,
    input  bmg_pkg::t_angle                     i_angle,
    output logic                                o_valid,
    output logic signed [bmg_pkg::OUT_W-1:0]    o_normal_cos,
    output logic signed [bmg_pkg::OUT_W-1:0]    o_normal_sin
);

    localparam int N  = bmg_pkg::CORDIC_STEPS;
    localparam int XW = bmg_pkg::XY_W;
    localparam int ZW = bmg_pkg::ZS_W;

    logic                 r_valid [0:N];
    logic signed [XW-1:0] r_x     [0:N];
    logic signed [XW-1:0] r_y     [0:N];
    logic signed [ZW-1:0] r_z     [0:N];
    bmg_pkg::t_quad       r_quad  [0:N];

    logic [54:0]          w_gprod;
    logic signed [XW-1:0] w_oc;
    logic signed [XW-1:0] w_os;

    logic                              r_o_valid;
    logic signed [bmg_pkg::OUT_W-1:0]  r_o_cos;
    logic signed [bmg_pkg::OUT_W-1:0]  r_o_sin;

    // round q.20 to q4.16 and clamp
    function automatic logic signed [bmg_pkg::OUT_W-1:0] to_out(
        input logic signed [XW-1:0] v);
        logic signed [XW:0]   t;
        logic signed [XW-4:0] sh;
        logic signed [bmg_pkg::OUT_W-1:0] r;
        t  = (XW+1)'(v) + (XW+1)'(8);
        sh = (XW-3)'(t >>> 4);
        if (sh > (XW-3)'(bmg_pkg::OUT_MAX)) begin
            r = bmg_pkg::OUT_MAX;
        end else if (sh < (XW-3)'(bmg_pkg::OUT_MIN)) begin
            r = bmg_pkg::OUT_MIN;
        end else begin
            r = bmg_pkg::OUT_W'(sh);
        end
        return r;
    endfunction

    // prescale radius by the cordic gain
    assign w_gprod = 55'(i_rad) * 55'(bmg_pkg::GAIN_Q32);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= XW'(w_gprod[54:32]);
            r_y[0]    <= '0;
            r_z[0]    <= ZW'(i_angle.z);
            r_quad[0] <= i_angle.quad;
        end
    end

    // rotation stages
    for (genvar i = 0; i < N; i++) begin : g_rot
        logic signed [XW-1:0] w_dx;
        logic signed [XW-1:0] w_dy;
        logic signed [ZW-1:0] w_at;

        assign w_dx = r_y[i] >>> i;
        assign w_dy = r_x[i] >>> i;
        assign w_at = ZW'(bmg_pkg::atan_q30(4'(i)));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[i+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[i+1] <= r_valid[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[i][ZW-1]) begin
                    r_x[i+1] <= r_x[i] - w_dx;
                    r_y[i+1] <= r_y[i] + w_dy;
                    r_z[i+1] <= r_z[i] - w_at;
                end else begin
                    r_x[i+1] <= r_x[i] + w_dx;
                    r_y[i+1] <= r_y[i] - w_dy;
                    r_z[i+1] <= r_z[i] + w_at;
                end
                r_quad[i+1] <= r_quad[i];
            end
        end
    end

    // quadrant fold
    always_comb begin
        unique case (r_quad[N])
            bmg_pkg::QUAD_0: begin w_oc = r_x[N];  w_os = r_y[N];  end
            bmg_pkg::QUAD_1: begin w_oc = -r_y[N]; w_os = r_x[N];  end
            bmg_pkg::QUAD_2: begin w_oc = -r_x[N]; w_os = -r_y[N]; end
            default:         begin w_oc = r_y[N];  w_os = -r_x[N]; end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_en) begin
            r_o_valid <= r_valid[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_o_cos <= to_out(w_oc);
            r_o_sin <= to_out(w_os);
        end
    end

    assign o_valid      = r_o_valid;
    assign o_normal_cos = r_o_cos;
    assign o_normal_sin = r_o_sin;

endmodule
